// File: rtl/obse_pkg.sv
// Order book slippage estimate: shared widths, constants and types.
// No dependencies; used by obse_div and order_book_slippage_estimate_top.
package obse_pkg;

  localparam int PRICE_W = 16;   // Q0.16 price
  localparam int SIZE_W  = 24;   // whole shares
  localparam int NOTL_W  = 40;   // Q24.16 notional
  localparam int FILL_W  = 46;   // filled notional sum
  localparam int WSUM_W  = 62;   // price-weighted fill sum, Q30.32
  localparam int DEN_W   = 62;   // best * filled
  localparam int NUM_W   = 76;   // |diff| * 10000
  localparam int QUO_W   = 30;   // basis points result
  localparam int MUL_W   = PRICE_W + SIZE_W;   // shared multiplier product

  localparam logic [NOTL_W-1:0]  TRADE_SIZE_RST = 40'd32768000;
  localparam logic [PRICE_W-1:0] BPS_SCALE      = 16'd10000;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: rtl/order_book_slippage_estimate_top.sv
// Order book slippage estimate, top level: stream ports, sequencer, shared multiplier.
// Depends on obse_pkg and obse_div.
// A counted level holds off the input through the avail, fill and weighted-sum steps; an ignored one stays idle.
// An estimate runs after a counted or an ignored last level through the denominator, difference,
//   numerator and divide steps; a zero estimate skips numerator and divide, an empty side goes straight to output.
// Reset: synchronous, clears control, trade_size returns to 32768000 (500.0 in Q24.16).
module order_book_slippage_estimate_top #(
  parameter int MAX_LEVELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: trade_size, unsigned Q24.16
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [39:0] cfg_data,
  // level input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] level_price, [39:16] level_size
  input  logic        s_tlast,   // last_level
  input  logic [1:0]  s_tuser,   // [0] book_empty, [1] book_side
  // estimate output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [29:0] impact_bps, [31:30] zero
  output logic        m_tuser    // [0] side_echo
);

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);

  // one-hot sequencer states
  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_AVAIL = 17'b00000000000000010,
    S_FILL  = 17'b00000000000000100,
    S_WLO   = 17'b00000000000001000,
    S_WHI   = 17'b00000000000010000,
    S_WACC  = 17'b00000000000100000,
    S_DEN0  = 17'b00000000001000000,
    S_DEN1  = 17'b00000000010000000,
    S_DEN2  = 17'b00000000100000000,
    S_DIFF  = 17'b00000001000000000,
    S_NUM0  = 17'b00000010000000000,
    S_NUM1  = 17'b00000100000000000,
    S_NUM2  = 17'b00001000000000000,
    S_NUM3  = 17'b00010000000000000,
    S_DIVGO = 17'b00100000000000000,
    S_DIV   = 17'b01000000000000000,
    S_OUT   = 17'b10000000000000000
  } state_t;

  state_t state;

  // configuration register
  logic [obse_pkg::NOTL_W-1:0]  trade_size;

  // captured beat
  logic [obse_pkg::PRICE_W-1:0] price;
  logic [obse_pkg::SIZE_W-1:0]  size;
  logic                         last;
  logic                         side;

  // book state
  logic [obse_pkg::NOTL_W-1:0]  remaining;
  logic [obse_pkg::WSUM_W-1:0]  wsum;
  logic [obse_pkg::FILL_W-1:0]  fsum;
  logic [obse_pkg::PRICE_W-1:0] best;
  logic                         at_start;
  logic                         fill_done;
  logic [CNT_W-1:0]             level_cnt;

  // working registers
  logic [obse_pkg::NOTL_W-1:0]  fill;
  logic [obse_pkg::DEN_W-1:0]   den;
  logic [obse_pkg::DEN_W-1:0]   diff;
  logic [obse_pkg::NUM_W-1:0]   num;
  logic                         zero_res;

  // shared multiplier
  logic [obse_pkg::PRICE_W-1:0] mul_a;
  logic [obse_pkg::SIZE_W-1:0]  mul_b;
  logic [obse_pkg::MUL_W-1:0]   mul_q;

  // divider
  logic                         div_start;
  logic [obse_pkg::QUO_W-1:0]   div_quo;
  obse_pkg::div_sts_t           div_sts;

  logic                         in_acc;
  logic [obse_pkg::NOTL_W-1:0]  fill_now;
  logic                         lvl_open;
  logic                         out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign div_start = (state == S_DIVGO);

  // fill of the current level: min(remaining, price * size)
  assign fill_now = (remaining < mul_q) ? remaining : mul_q;
  // a level counts unless the trade is filled or the level cap is reached
  assign lvl_open = !fill_done && (level_cnt < CNT_W'(MAX_LEVELS));

  // select the multiplier operands for each step
  always_comb begin
    mul_a = price;
    mul_b = size;
    case (state)
      S_WLO:  mul_b = fill[23:0];
      S_WHI:  mul_b = {8'd0, fill[39:24]};
      S_DEN0: begin
        mul_a = best;
        mul_b = fsum[23:0];
      end
      S_DEN1: begin
        mul_a = best;
        mul_b = {2'd0, fsum[45:24]};
      end
      S_NUM0: begin
        mul_a = obse_pkg::BPS_SCALE;
        mul_b = diff[23:0];
      end
      S_NUM1: begin
        mul_a = obse_pkg::BPS_SCALE;
        mul_b = diff[47:24];
      end
      S_NUM2: begin
        mul_a = obse_pkg::BPS_SCALE;
        mul_b = {10'd0, diff[61:48]};
      end
      default: begin
        mul_a = price;
        mul_b = size;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= obse_pkg::MUL_W'(mul_a) * obse_pkg::MUL_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trade_size <= obse_pkg::TRADE_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      trade_size <= cfg_data;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      at_start  <= 1'b1;
      fill_done <= 1'b0;
      level_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // raise tvalid as the estimate is loaded, drop it once the beat is taken
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_tuser[0]) begin
              // empty book: drop any book in progress, answer zero
              at_start <= 1'b1;
              state    <= S_OUT;
            end else if (at_start) begin
              at_start  <= 1'b0;
              fill_done <= 1'b0;
              level_cnt <= '0;
              state     <= S_AVAIL;
            end else if (lvl_open) begin
              state <= S_AVAIL;
            end else if (s_tlast) begin
              state <= S_DEN0;
            end
          end
        end
        S_AVAIL: state <= S_FILL;
        S_FILL: begin
          fill_done <= (remaining == fill_now);
          level_cnt <= level_cnt + 1'b1;
          state     <= S_WLO;
        end
        S_WLO:  state <= S_WHI;
        S_WHI:  state <= S_WACC;
        S_WACC: state <= last ? S_DEN0 : S_IDLE;
        S_DEN0: state <= S_DEN1;
        S_DEN1: state <= S_DEN2;
        S_DEN2: state <= S_DIFF;
        S_DIFF: state <= (best == '0 || fsum == '0) ? S_OUT : S_NUM0;
        S_NUM0: state <= S_NUM1;
        S_NUM1: state <= S_NUM2;
        S_NUM2: state <= S_NUM3;
        S_NUM3: state <= S_DIVGO;
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (div_sts.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold here, input stalled, while the previous estimate waits
          if (out_free) begin
            at_start <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          price    <= s_tdata[15:0];
          size     <= s_tdata[39:16];
          last     <= s_tlast;
          side     <= s_tuser[1];
          zero_res <= s_tuser[0];
          if (!s_tuser[0] && at_start) begin
            // book start: load trade size, clear sums, take best price
            remaining <= trade_size;
            wsum      <= '0;
            fsum      <= '0;
            best      <= s_tdata[15:0];
          end
        end
      end
      S_FILL: begin
        fill      <= fill_now;
        fsum      <= fsum + obse_pkg::FILL_W'(fill_now);
        remaining <= remaining - fill_now;
      end
      S_WHI:  wsum <= wsum + obse_pkg::WSUM_W'(mul_q);
      S_WACC: wsum <= wsum + obse_pkg::WSUM_W'({mul_q, 24'd0});
      S_DEN1: den  <= obse_pkg::DEN_W'(mul_q);
      S_DEN2: den  <= den + obse_pkg::DEN_W'({mul_q, 24'd0});
      S_DIFF: begin
        zero_res <= (best == '0 || fsum == '0);
        diff     <= (wsum >= den) ? wsum - den : den - wsum;
      end
      S_NUM1: num <= obse_pkg::NUM_W'(mul_q);
      S_NUM2: num <= num + obse_pkg::NUM_W'({mul_q, 24'd0});
      S_NUM3: num <= num + obse_pkg::NUM_W'({mul_q, 48'd0});
      S_OUT: begin
        if (out_free) begin
          m_tdata <= {2'd0, (zero_res ? {obse_pkg::QUO_W{1'b0}} : div_quo)};
          m_tuser <= side;
        end
      end
      default: begin
      end
    endcase
  end

  obse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  a_fill_done_empty: assert property (@(posedge clk) disable iff (rst)
    fill_done |-> remaining == '0) else $error("fill marked complete with notional left");
  a_level_cap: assert property (@(posedge clk) disable iff (rst)
    level_cnt <= CNT_W'(MAX_LEVELS)) else $error("level count beyond cap");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    div_start |-> den != '0) else $error("divider started with zero divisor");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_sts.busy |-> state == S_DIV) else $error("divider busy outside divide step");

endmodule

// File: rtl/obse_div.sv
// Restoring divider: floor(num / den), one quotient bit per cycle.
// Depends on obse_pkg; requires num < den * 2**QUO_W and den != 0.
module obse_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [obse_pkg::NUM_W-1:0]   num,
  input  logic [obse_pkg::DEN_W-1:0]   den,
  output logic [obse_pkg::QUO_W-1:0]   quo,
  output obse_pkg::div_sts_t           sts
);

  localparam int CNT_W = $clog2(obse_pkg::QUO_W);

  logic [obse_pkg::DEN_W-1:0] rem;
  logic [obse_pkg::QUO_W-1:0] nsh;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic                       done;
  logic [obse_pkg::DEN_W:0]   trial;
  logic                       fits;

  assign trial = {rem, nsh[obse_pkg::QUO_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= obse_pkg::DEN_W'(num[obse_pkg::NUM_W-1:obse_pkg::QUO_W]);
      nsh <= num[obse_pkg::QUO_W-1:0];
      cnt <= CNT_W'(obse_pkg::QUO_W - 1);
      quo <= '0;
    end else if (busy) begin
      // bring in the next numerator bit, subtract when it fits
      rem <= fits ? obse_pkg::DEN_W'(trial - {1'b0, den})
                  : obse_pkg::DEN_W'(trial);
      nsh <= {nsh[obse_pkg::QUO_W-2:0], 1'b0};
      quo <= {quo[obse_pkg::QUO_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den) else $error("divider remainder not below divisor");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy) else $error("divider done not a single pulse");

endmodule

// File: tb/sv/obse_slippage_checker.sv
// Slippage estimate checker: watches the config, level and estimate channels,
// predicts every estimate and compares it with the beat that leaves the block.
// Depends on obse_pkg.
module obse_slippage_checker #(
  parameter int MAX_LEVELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [39:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] level_price, [39:16] level_size
  input  logic        s_tlast,   // last_level
  input  logic [1:0]  s_tuser,   // [0] book_empty, [1] book_side
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [29:0] impact_bps, [31:30] zero
  input  logic        m_tuser,   // [0] side_echo
  output int          mismatch_count,
  output int          estimates_pending
);

  typedef struct packed {
    logic [obse_pkg::QUO_W-1:0] bps;
    logic                       side;
  } estimate_t;

  estimate_t                      estimates_due[$];
  estimate_t                      oldest;
  logic [obse_pkg::NOTL_W-1:0]    trade_size;
  logic [obse_pkg::NOTL_W-1:0]    remaining;
  logic [63:0]                    weighted;
  logic [63:0]                    filled;
  logic [obse_pkg::PRICE_W-1:0]   best;
  logic                           at_start;
  logic                           fill_done;
  int                             level_count;

  // floor(|W - best*F| * 10000 / (best*F)), low bits of the quotient kept; zero when best or F is zero
  function automatic logic [obse_pkg::QUO_W-1:0] impact_bps(
      input logic [obse_pkg::PRICE_W-1:0] bp,
      input logic [63:0] w,
      input logic [63:0] f);
    logic [127:0] den;
    logic [127:0] diff;
    if (bp == '0 || f == '0) return '0;
    den  = 128'(bp) * 128'(f);
    diff = (128'(w) >= den) ? 128'(w) - den : den - 128'(w);
    return obse_pkg::QUO_W'((diff * 128'(obse_pkg::BPS_SCALE)) / den);
  endfunction

  task automatic open_book();
    remaining   = trade_size;
    weighted    = '0;
    filled      = '0;
    best        = '0;
    fill_done   = 1'b0;
    level_count = 0;
    at_start    = 1'b1;
  endtask

  // append one predicted estimate at the tail of the queue
  task automatic queue_estimate(input logic [obse_pkg::QUO_W-1:0] bps, input logic side);
    estimate_t entry;
    entry.bps     = bps;
    entry.side    = side;
    estimates_due = {estimates_due, entry};
  endtask

  task automatic take_level(input logic [obse_pkg::PRICE_W-1:0] price,
                            input logic [obse_pkg::SIZE_W-1:0] size,
                            input logic last, input logic empty, input logic side);
    logic [63:0] avail;
    logic [63:0] fill;
    if (empty) begin
      open_book();
      queue_estimate('0, side);
      return;
    end
    if (at_start) begin
      open_book();
      best     = price;
      at_start = 1'b0;
    end
    if (!fill_done && level_count < MAX_LEVELS) begin
      avail    = 64'(price) * 64'(size);
      fill     = (64'(remaining) < avail) ? 64'(remaining) : avail;
      weighted = weighted + 64'(price) * fill;
      filled   = filled + fill;
      remaining = remaining - fill[obse_pkg::NOTL_W-1:0];
      if (remaining == '0) fill_done = 1'b1;
      level_count++;
    end
    if (last) begin
      queue_estimate(impact_bps(best, weighted, filled), side);
      open_book();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      trade_size = obse_pkg::TRADE_SIZE_RST;
      open_book();
      remaining = '0;
      estimates_due.delete();
      mismatch_count = 0;
    end else begin
      // retire the outgoing beat first: it can never belong to a level taken at this edge
      if (m_tvalid && m_tready) begin
        if (estimates_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected estimate: data 0x%08h side %0d", m_tdata, m_tuser);
        end else begin
          oldest = estimates_due.pop_front();
          if (m_tdata !== 32'(oldest.bps) || m_tuser !== oldest.side) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("estimate mismatch: expected bps %0d side %0d, got data 0x%08h side %0d",
                       oldest.bps, oldest.side, m_tdata, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready)
        take_level(s_tdata[obse_pkg::PRICE_W-1:0],
                   s_tdata[obse_pkg::PRICE_W +: obse_pkg::SIZE_W], s_tlast,
                   s_tuser[0], s_tuser[1]);
      // a level taken at the same edge still sees the old trade size
      if (cfg_valid && cfg_ready) trade_size = cfg_data;
    end
    estimates_pending = estimates_due.size();
  end

endmodule

// File: tb/sv/tb_order_book_slippage_estimate_top.sv
// Testbench top for the order book slippage estimate: clock, reset, level stimulus,
// trade size writes, receiver back-pressure and the verdict.
// Depends on obse_pkg, order_book_slippage_estimate_top and obse_slippage_checker.
module tb_order_book_slippage_estimate_top;

  localparam int LEVEL_CAP     = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 60;    // a margin beyond the estimate latency
  localparam int TAIL_CYCLES   = 100;
  localparam int LONG_HOLD     = 400;   // receiver hold-off, long enough to back up the block
  localparam int PHASES        = 7;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [39:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [15:0] level_price, [39:16] level_size
  logic        s_tlast;   // last_level
  logic [1:0]  s_tuser;   // [0] book_empty, [1] book_side
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [29:0] impact_bps, [31:30] zero
  logic        m_tuser;   // [0] side_echo

  int mismatch_count;
  int estimates_pending;
  int cycle_count = 0;
  int beats_sent  = 0;
  int tx_gap_pct  = 0;    // chance of a sender gap after each beat
  int rx_stall_pct = 0;   // chance of a receiver stall after each ready cycle
  int hold_asks   = 0;    // bumped by the stimulus to request one long hold-off

  order_book_slippage_estimate_top #(.MAX_LEVELS(LEVEL_CAP)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  obse_slippage_checker #(.MAX_LEVELS(LEVEL_CAP)) u_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tlast           (s_tlast),
    .s_tuser           (s_tuser),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .mismatch_count    (mismatch_count),
    .estimates_pending (estimates_pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Count cycles and give up at the limit; a correct run stays far below it.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Drop tvalid for a random gap after a beat: mostly short, now and then long.
  task automatic tx_gap();
    int n;
    n = 0;
    if ($urandom_range(99) < tx_gap_pct)
      n = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // Offer one level beat at the falling edge and hold it until the block takes it.
  // Without a gap tvalid simply stays high into the next beat.
  task automatic send_beat(input int price, input int size, input bit last,
                           input bit empty, input bit side);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {obse_pkg::SIZE_W'(size), obse_pkg::PRICE_W'(price)};
    s_tlast  <= last;
    s_tuser  <= {side, empty};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    tx_gap();
  endtask

  // Quiesce the level channel, wait out every estimate, then let the divider settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (estimates_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_trade_size(input logic [obse_pkg::NOTL_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stream one book side: best price first, later levels walk away from it
  // (up for asks, down for bids), with occasional off-trend prices and sides.
  task automatic play_book(input int len, input int size_max);
    int  best;
    int  step;
    int  price;
    int  size;
    int  r;
    bit  side;
    side = $urandom_range(1);
    r = $urandom_range(15);
    if (r == 0)      best = 0;
    else if (r == 1) best = 16'hFFFF;
    else if (r == 2) best = $urandom_range(1, 255);
    else             best = $urandom_range(16'hFFFF);
    step = ($urandom_range(3) == 0) ? $urandom_range(4000) : $urandom_range(300);
    for (int i = 0; i < len; i++) begin
      price = side ? best + i * step : best - i * step;
      if (price > 16'hFFFF) price = 16'hFFFF;
      if (price < 0) price = 0;
      if (i > 0 && $urandom_range(9) == 0) price = $urandom_range(16'hFFFF);
      r = $urandom_range(19);
      if (r < 2)       size = 0;
      else if (r == 2) size = 24'hFFFFFF;
      else if (r == 3) size = $urandom_range(24'hFFFFFF);
      else             size = $urandom_range(size_max);
      send_beat(price, size, i == len - 1, 1'b0,
                ($urandom_range(9) == 0) ? !side : side);
    end
  endtask

  // Mostly well-formed books with random content; some empty sides, books past
  // the level cap and loose levels with random end marks.
  task automatic run_phase(input int quota);
    int target;
    int r;
    target = beats_sent + quota;
    while (beats_sent < target) begin
      r = $urandom_range(99);
      if (r < 8)
        send_beat($urandom_range(16'hFFFF), $urandom_range(24'hFFFFFF), $urandom_range(1),
                  1'b1, $urandom_range(1));
      else if (r < 9)
        play_book($urandom_range(LEVEL_CAP + 1, LEVEL_CAP + 8), 15);
      else if (r < 13)
        send_beat($urandom_range(16'hFFFF), $urandom_range(24'hFFFFFF), $urandom_range(1),
                  1'b0, $urandom_range(1));
      else if (r < 50)
        play_book($urandom_range(1, 8), 4095);
      else if (r < 80)
        play_book($urandom_range(1, 8), 255);
      else
        play_book($urandom_range(1, 8), 24'hFFFFFF);
    end
    // close any book left open by a loose level
    send_beat($urandom_range(16'hFFFF), $urandom_range(255), 1'b1, 1'b0, $urandom_range(1));
  endtask

  // Receiver: ready with random stalls, plus the long hold-off counted here.
  initial begin
    int stall;
    int holds_served;
    stall        = 0;
    holds_served = 0;
    m_tready     = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_asks) begin
        holds_served++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(99) < rx_stall_pct)
          stall = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    logic [obse_pkg::NOTL_W-1:0] phase_size [PHASES];
    int                          phase_quota[PHASES];
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    s_tuser   = '0;

    // Trade size per phase: zero, the smallest step, the largest value, the reset
    // value, a random full-width value, a random small one and 5000.0.
    phase_size[0] = '0;
    phase_size[1] = obse_pkg::NOTL_W'(1);
    phase_size[2] = {obse_pkg::NOTL_W{1'b1}};
    phase_size[3] = obse_pkg::TRADE_SIZE_RST;
    phase_size[4] = obse_pkg::NOTL_W'({$urandom, $urandom});
    phase_size[5] = obse_pkg::NOTL_W'($urandom_range(1, 1 << 26));
    phase_size[6] = obse_pkg::NOTL_W'(64'd5000 << 16);
    phase_quota   = '{150, 150, 250, 350, 250, 400, 400};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed books at the reset trade size of 500.0, no idling on either side.
    // Empty sides, both book sides.
    send_beat(16'h1234, 24'h00ABCD, 1'b0, 1'b1, 1'b0);
    send_beat(16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
    // Largest price and size in a single level: the trade size caps the fill.
    send_beat(16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b1);
    // Zero best price: the estimate is zero whatever follows.
    send_beat(0, 100, 1'b0, 1'b0, 1'b1);
    send_beat(1000, 1000, 1'b1, 1'b0, 1'b1);
    // Nothing filled: a zero-size single level.
    send_beat(5000, 0, 1'b1, 1'b0, 1'b0);
    // Trade size used up on the first level; the rest is ignored but last still ends it.
    send_beat(32768, 20000, 1'b0, 1'b0, 1'b1);
    send_beat(40000, 100, 1'b0, 1'b0, 1'b1);
    send_beat(50000, 5, 1'b1, 1'b0, 1'b1);
    // Ask side walking up, filled across three levels.
    send_beat(30000, 500, 1'b0, 1'b0, 1'b1);
    send_beat(31000, 500, 1'b0, 1'b0, 1'b1);
    send_beat(33000, 2000, 1'b1, 1'b0, 1'b1);
    // Bid side walking down.
    send_beat(60000, 300, 1'b0, 1'b0, 1'b0);
    send_beat(50000, 300, 1'b0, 1'b0, 1'b0);
    send_beat(40000, 10000, 1'b1, 1'b0, 1'b0);
    // An empty side cuts short a book in progress.
    send_beat(20000, 10, 1'b0, 1'b0, 1'b0);
    send_beat(16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
    // Smallest nonzero level, then a level that fills less than its size allows.
    send_beat(1, 1, 1'b1, 1'b0, 1'b0);
    send_beat(16'h8000, 24'h800000, 1'b0, 1'b0, 1'b0);
    send_beat(16'h7FFF, 24'h7FFFFF, 1'b1, 1'b0, 1'b1);

    // Random phases; the first runs with no idling, two carry a long hold-off.
    for (int k = 0; k < PHASES; k++) begin
      write_trade_size(phase_size[k]);
      tx_gap_pct   = (k == 0) ? 0 : $urandom_range(10, 50);
      rx_stall_pct = (k == 0) ? 0 : $urandom_range(10, 50);
      if (k == 3 || k == 5) hold_asks++;
      run_phase(phase_quota[k]);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (estimates_pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && estimates_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: order_book_slippage_estimate_top.f
rtl/obse_pkg.sv
rtl/obse_div.sv
rtl/order_book_slippage_estimate_top.sv
tb/sv/obse_slippage_checker.sv
tb/sv/tb_order_book_slippage_estimate_top.sv
